// ===== rtl/barc_pkg.sv =====
// Shared types and constants for the barometer raw compensation pipeline.
package barc_pkg;

    // Input item: one pair of raw converter readings.
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } t_in_item;

    // Result item: compensated temperature and pressure.
    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_out_item;

    // Temperature results and flags that ride alongside the divider.
    typedef struct packed {
        logic [31:0] cent;
        logic [31:0] fine;
        logic        neg;
        logic        invalid;
    } t_side;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        CFG_TEMP_CAL  = 8'd0,
        CFG_PRESS_A   = 8'd1,
        CFG_PRESS_B   = 8'd2,
        CFG_PRESS_C   = 8'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W = 8;
    localparam int DIV_W     = 64;   // dividend and quotient width
    localparam int DEN_W     = 31;   // divisor magnitude width
    localparam logic [32:0] T_FINE_OFFSET = 33'd128000;
    localparam logic [20:0] P_ADC_FULL    = 21'd1048576;
    localparam logic [63:0] P_SCALE       = 64'd3125;
    localparam logic [63:0] P_BIAS        = 64'h0000_8000_0000_0000;

endpackage

// ===== rtl/barc_div.sv =====
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
module barc_div import barc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_quo,
    output t_side            o_side
);

    logic [DIV_W-1:0] w_num [0:DIV_W];
    logic [DEN_W-1:0] w_rem [0:DIV_W];
    logic [DEN_W-1:0] w_den [0:DIV_W];
    t_side            w_sd  [0:DIV_W];
    logic [DIV_W:0]   w_v;

    // Stage zero is fed straight from the inputs with an empty remainder.
    assign w_num[0] = i_num;
    assign w_rem[0] = '0;
    assign w_den[0] = i_den;
    assign w_sd[0]  = i_side;
    assign w_v[0]   = i_valid;

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W-1:0] r_num;
        logic [DEN_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        t_side            r_sd;
        logic             r_v;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        // Shift in the next dividend bit and try to subtract the divisor.
        assign trial = {w_rem[k], w_num[k][DIV_W-1]};
        assign diff  = trial - {1'b0, w_den[k]};
        assign ge    = trial >= {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_num <= {w_num[k][DIV_W-2:0], ge};
                r_den <= w_den[k];
                r_sd  <= w_sd[k];
            end
        end

        assign w_num[k+1] = r_num;
        assign w_rem[k+1] = r_rem;
        assign w_den[k+1] = r_den;
        assign w_sd[k+1]  = r_sd;
        assign w_v[k+1]   = r_v;
    end

    assign o_valid = w_v[DIV_W];
    assign o_quo   = w_num[DIV_W];
    assign o_side  = w_sd[DIV_W];

endmodule

// ===== rtl/barometer_raw_compensation.sv =====
// Path: stages 1 to 9, the divider, stages A to D and the output stage, all registered.
// Throughput: one item per cycle unless a held result stalls it; the 64-stage divider sets the depth.
// All stages advance together; a held result stalls the whole pipeline.
// Reset (synchronous, active low) clears every valid bit and the
// calibration registers; results in flight are dropped.
module barometer_raw_compensation import barc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    // Calibration registers.
    logic [47:0] r_tcal;
    logic [63:0] r_pca;
    logic [63:0] r_pcb;
    logic [15:0] r_pcc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_pca  <= '0;
            r_pcb  <= '0;
            r_pcc  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_CAL: r_tcal <= i_cfg_data[47:0];
                CFG_PRESS_A:  r_pca  <= i_cfg_data;
                CFG_PRESS_B:  r_pcb  <= i_cfg_data;
                CFG_PRESS_C:  r_pcc  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Coefficient slices.
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_tcal[15:0];
    assign t2 = r_tcal[31:16];
    assign t3 = r_tcal[47:32];
    assign p1 = r_pca[15:0];
    assign p2 = r_pca[31:16];
    assign p3 = r_pca[47:32];
    assign p4 = r_pca[63:48];
    assign p5 = r_pcb[15:0];
    assign p6 = r_pcb[31:16];
    assign p7 = r_pcb[47:32];
    assign p8 = r_pcb[63:48];
    assign p9 = r_pcc;

    // The pipeline moves as one unless a finished result is being held.
    logic en;
    logic r_vo;
    assign en      = !(r_vo && i_stall);
    assign o_stall = !en;

    // Valid bits of the stages around the divider.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_va, r_vb, r_vc, r_vd;
    logic dv_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9} <= '0;
            {r_va, r_vb, r_vc, r_vd, r_vo} <= '0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
            r_va <= dv_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_vo <= r_vd;
        end
    end

    // Stage 1: the two temperature products.
    logic signed [17:0] s1_da, s1_dd;
    logic signed [33:0] s1_pa;
    logic signed [35:0] s1_pd;
    logic [31:0] r1_pa, r1_dd;
    logic [19:0] r1_adp;
    assign s1_da = $signed({1'b0, i_item.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_dd = $signed({2'b0, i_item.raw_temperature[19:4]}) - $signed({2'b0, t1});
    assign s1_pa = s1_da * t2;
    assign s1_pd = s1_dd * s1_dd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pa  <= s1_pa[31:0];
            r1_dd  <= s1_pd[31:0];
            r1_adp <= i_item.raw_pressure;
        end
    end

    // Stage 2: scale the first term and form the quadratic term.
    logic signed [31:0] s2_dd;
    logic signed [47:0] s2_pb;
    logic [31:0] r2_a, r2_bp;
    logic [19:0] r2_adp;
    assign s2_dd = $signed(r1_dd) >>> 12;
    assign s2_pb = s2_dd * t3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_a   <= $signed(r1_pa) >>> 11;
            r2_bp  <= s2_pb[31:0];
            r2_adp <= r1_adp;
        end
    end

    // Stage 3: fine temperature.
    logic [31:0] s3_b;
    logic [31:0] r3_fine;
    logic [19:0] r3_adp;
    assign s3_b = $signed(r2_bp) >>> 14;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_fine <= r2_a + s3_b;
            r3_adp  <= r2_adp;
        end
    end

    // Stage 4: centidegrees and the first pressure products.
    logic [31:0]        s4_c5;
    logic signed [32:0] s4_x;
    logic signed [65:0] s4_xx;
    logic signed [48:0] s4_xp5, s4_xp2;
    logic [31:0] r4_cent, r4_fine;
    logic [19:0] r4_adp;
    logic [63:0] r4_xx;
    logic [48:0] r4_xp5, r4_xp2;
    assign s4_c5  = {r3_fine[29:0], 2'b0} + r3_fine + 32'd128;
    assign s4_x   = $signed({r3_fine[31], r3_fine}) - $signed(T_FINE_OFFSET);
    assign s4_xx  = s4_x * s4_x;
    assign s4_xp5 = s4_x * p5;
    assign s4_xp2 = s4_x * p2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_cent <= $signed(s4_c5) >>> 8;
            r4_fine <= r3_fine;
            r4_adp  <= r3_adp;
            r4_xx   <= s4_xx[63:0];
            r4_xp5  <= s4_xp5;
            r4_xp2  <= s4_xp2;
        end
    end

    // Stage 5: square term times P6 and P3 (64 by 16 signed products).
    logic [63:0] s5_p6, s5_p3;
    logic [31:0] r5_cent, r5_fine;
    logic [19:0] r5_adp;
    logic [63:0] r5_y1, r5_x1;
    logic [48:0] r5_xp5, r5_xp2;
    assign s5_p6 = $signed(r4_xx) * p6;
    assign s5_p3 = $signed(r4_xx) * p3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_cent <= r4_cent;
            r5_fine <= r4_fine;
            r5_adp  <= r4_adp;
            r5_y1   <= s5_p6;
            r5_x1   <= s5_p3;
            r5_xp5  <= r4_xp5;
            r5_xp2  <= r4_xp2;
        end
    end

    // Stage 6: sums for the offset term and the divisor base.
    logic [63:0] s6_xp5, s6_xp2, s6_p4, s6_x1;
    logic [20:0] s6_pm;
    logic [31:0] r6_cent, r6_fine;
    logic [63:0] r6_y, r6_v, r6_pd;
    assign s6_xp5 = {{15{r5_xp5[48]}}, r5_xp5} << 17;
    assign s6_xp2 = {{15{r5_xp2[48]}}, r5_xp2} << 12;
    assign s6_p4  = {{48{p4[15]}}, p4} << 35;
    assign s6_x1  = $signed(r5_x1) >>> 8;
    assign s6_pm  = P_ADC_FULL - {1'b0, r5_adp};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_cent <= r5_cent;
            r6_fine <= r5_fine;
            r6_y    <= r5_y1 + s6_xp5 + s6_p4;
            r6_v    <= P_BIAS + s6_x1 + s6_xp2;
            r6_pd   <= {12'b0, s6_pm, 31'b0};
        end
    end

    // Stage 7: divisor product and dividend base.
    logic [63:0] r7_dp, r7_nd;
    logic [31:0] r7_cent, r7_fine;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_dp   <= r6_v * {48'b0, p1};
            r7_nd   <= r6_pd - r6_y;
            r7_cent <= r6_cent;
            r7_fine <= r6_fine;
        end
    end

    // Stage 8: final divisor and scaled dividend.
    logic [30:0] r8_dv;
    logic [63:0] r8_n;
    logic [31:0] r8_cent, r8_fine;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_dv   <= r7_dp[63:33];
            r8_n    <= r7_nd * P_SCALE;
            r8_cent <= r7_cent;
            r8_fine <= r7_fine;
        end
    end

    // Stage 9: magnitudes and quotient sign.
    logic [DIV_W-1:0] r9_nmag;
    logic [DEN_W-1:0] r9_dmag;
    t_side            r9_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_nmag       <= r8_n[63] ? (64'd0 - r8_n) : r8_n;
            r9_dmag       <= r8_dv[30] ? (31'd0 - r8_dv) : r8_dv;
            r9_sd.cent    <= r8_cent;
            r9_sd.fine    <= r8_fine;
            r9_sd.neg     <= r8_n[63] ^ r8_dv[30];
            r9_sd.invalid <= (r8_dv == 31'd0);
        end
    end

    // Pipelined division of the magnitudes.
    logic [DIV_W-1:0] dv_quo;
    t_side            dv_sd;

    barc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v9),
        .i_num   (r9_nmag),
        .i_den   (r9_dmag),
        .i_side  (r9_sd),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_side  (dv_sd)
    );

    // Stage A: restore the quotient sign.
    logic [63:0] ra_q;
    t_side       ra_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_q  <= dv_sd.neg ? (64'd0 - dv_quo) : dv_quo;
            ra_sd <= dv_sd;
        end
    end

    // Stage B: P9 and P8 products (64 by 16 signed).
    logic [63:0] sb_qs, sb_p8;
    logic [63:0] rb_q, rb_qs, rb_p9q, rb_y8;
    t_side       rb_sd;
    assign sb_qs = $signed(ra_q) >>> 13;
    assign sb_p8 = p8 * $signed(ra_q);

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_q   <= ra_q;
            rb_qs  <= sb_qs;
            rb_p9q <= p9 * $signed(sb_qs);
            rb_y8  <= $signed(sb_p8) >>> 19;
            rb_sd  <= ra_sd;
        end
    end

    // Stage C: partial products of the low 64 bits of p9q times qs.
    logic [63:0] rc_ll, rc_q, rc_y8;
    logic [31:0] rc_c1, rc_c2;
    t_side       rc_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rc_ll <= rb_p9q[31:0] * rb_qs[31:0];
            rc_c1 <= rb_p9q[31:0] * rb_qs[63:32];
            rc_c2 <= rb_p9q[63:32] * rb_qs[31:0];
            rc_q  <= rb_q;
            rc_y8 <= rb_y8;
            rc_sd <= rb_sd;
        end
    end

    // Stage D: assemble the cubic term and scale it.
    logic [63:0] sd_m;
    logic [63:0] rd_xs, rd_q, rd_y8;
    t_side       rd_sd;
    assign sd_m = rc_ll + {rc_c1 + rc_c2, 32'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_xs <= $signed(sd_m) >>> 25;
            rd_q  <= rc_q;
            rd_y8 <= rc_y8;
            rd_sd <= rc_sd;
        end
    end

    // Output stage: final sum in Q24.8, forced to zero on a zero divisor.
    logic [39:0] so_s;
    logic [31:0] so_p;
    t_out_item   r_out;
    assign so_s = rd_q[39:0] + rd_xs[39:0] + rd_y8[39:0];
    assign so_p = so_s[39:8] + {{12{p7[15]}}, p7, 4'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.temperature_centi <= rd_sd.cent;
            r_out.fine_temperature  <= rd_sd.fine;
            r_out.pressure_q24_8    <= rd_sd.invalid ? 32'd0 : so_p;
            r_out.pressure_invalid  <= rd_sd.invalid;
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_out;

endmodule

// ===== rtl/barc_chk.sv =====
// Port-level checker for the barometer raw compensation block, with its bind.
module barc_chk import barc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // A result held by the receiver keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("held result changed");

    // Input backpressure only comes from a held result.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A zero divisor always reports zero pressure.
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.pressure_invalid) |-> (o_item.pressure_q24_8 == 32'd0))
        else $error("invalid pressure not zero");

    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind barometer_raw_compensation barc_chk u_barc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
